[rtl/rog_pkg.sv]
// Shared types, constants and helpers for the radar occupancy grid update block.
// No dependencies; every other file in rtl/ except rog_grid_ram imports this package.

package rog_pkg;

  // Grid geometry. GRID_SIDE must be a power of two from 16 to 4096.
  localparam int GRID_SIDE  = 1024;
  localparam int SIDE_W     = $clog2(GRID_SIDE);
  localparam int ADDR_W     = 2 * SIDE_W;
  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

  // Echo samples per sector.
  localparam int MAX_ECHOES = 4096;
  localparam int IDX_W      = $clog2(MAX_ECHOES);
  localparam int CNT_W      = IDX_W + 1;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int TRIG_W   = 16;
  localparam int STEP_W   = 16;
  localparam int INT_W    = 8;
  localparam int CELL_W   = 15;
  localparam int HIT_W    = 7;
  localparam int OCC_W    = 7;
  localparam int OUT_IDX_W = 20;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  // Echo arithmetic widths: range is Q20.8, range times Q1.15 gives Q.23.
  localparam int RANGE_W = IDX_W + STEP_W;
  localparam int PROD_W  = RANGE_W + 1 + TRIG_W;
  localparam int FRAC_W  = 23;
  localparam int COORD_W = PROD_W - FRAC_W;
  localparam int GX_W    = COORD_W + 1;
  localparam int HITP_W  = HIT_W + INT_W;
  localparam int INCN_W  = HITP_W + 8;
  localparam int RECIP_W = 24;
  localparam int RECIP_SH = 27;
  localparam int INCP_W  = INCN_W + RECIP_W;
  localparam int INC_W   = INCP_W - RECIP_SH;
  localparam int SUM_W   = INC_W + 1;

  // ceil(2^27 / 15): exact floor(n / 15) for any n below 2^23.
  localparam logic [RECIP_W-1:0] RECIP15 = 24'd8947849;

  localparam logic [CELL_W-1:0] CELL_MAX       = 15'd25600;
  localparam logic [INT_W-1:0]  HIT_THRESHOLD  = 8'd5;
  localparam logic [HIT_W-1:0]  HIT_INC_RESET  = 7'd15;
  localparam logic [CELL_W-1:0] DECAY_RESET    = 15'd51;

  // Operation codes carried in tuser.
  localparam logic [OP_W-1:0] OP_SECTOR = 2'd0;
  localparam logic [OP_W-1:0] OP_ECHO   = 2'd1;
  localparam logic [OP_W-1:0] OP_DECAY  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_HIT_INC = 1'b0;
  localparam logic CFG_DECAY   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // write zero at the clear pointer and advance it
    logic load_beam;  // capture cosine, sine and range step, zero the counter
    logic echo_start; // capture sample index and intensity, bump the counter
    logic e_mul1;     // range and raw increment products
    logic e_mul2;     // coordinate products and scaled increment
    logic e_addr;     // map to a cell and read it when on the grid
    logic e_write;    // saturating add and write back
    logic d_read;     // read the cell under the sweep pointer
    logic d_write;    // decay, write back, publish and advance the sweep
  } rog_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_full;
    logic            hot;
    logic            on_grid;
    logic            clr_last;
    logic            out_busy;
  } rog_sts_t;

  // Cell address to the published 20-bit index, truncated or zero-extended.
  function automatic logic [OUT_IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
    logic [OUT_IDX_W-1:0] r;
    r = '0;
    for (int b = 0; b < OUT_IDX_W; b++) begin
      if (b < ADDR_W) begin
        r[b] = a[b];
      end
    end
    return r;
  endfunction

endpackage

[rtl/rog_grid_ram.sv]
// Simple dual-port RAM holding the occupancy grid: one write, one registered read.
// No package dependency; sized by its parameters.

module rog_grid_ram #(
  parameter int ADDR_BITS = 20,
  parameter int DATA_BITS = 15
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rog_dp.sv]
// Datapath of the occupancy grid block: beam registers, echo arithmetic, grid
// memory, decay sweep and output register. Depends on rog_pkg and rog_grid_ram.

module rog_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rog_pkg::rog_cmd_t             cmd_i,
  output rog_pkg::rog_sts_t             sts_o,
  input  logic [rog_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [rog_pkg::OP_W-1:0]      in_tuser,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rog_pkg::CELL_W-1:0]    cfg_wdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rog_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);

  import rog_pkg::*;

  // Unpacked input fields.
  logic signed [TRIG_W-1:0] in_cos;
  logic signed [TRIG_W-1:0] in_sin;
  logic [STEP_W-1:0]        in_step;
  logic [INT_W-1:0]         in_int;

  assign in_cos  = in_tdata[15:0];
  assign in_sin  = in_tdata[31:16];
  assign in_step = in_tdata[47:32];
  assign in_int  = in_tdata[55:48];

  // Configuration.
  logic [HIT_W-1:0]  hit_inc_r;
  logic [CELL_W-1:0] decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_inc_r <= HIT_INC_RESET;
      decay_r   <= DECAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIT_INC: hit_inc_r <= cfg_wdata[HIT_W-1:0];
        CFG_DECAY:   decay_r   <= cfg_wdata;
        default:     hit_inc_r <= hit_inc_r;
      endcase
    end
  end

  // Beam state and sample counter.
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;
  logic [STEP_W-1:0]        step_r;
  logic [CNT_W-1:0]         count_r;
  logic [IDX_W-1:0]         samp_idx_r;
  logic [INT_W-1:0]         inten_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= '0;
      sin_r   <= '0;
      step_r  <= '0;
      count_r <= '0;
    end else if (cmd_i.load_beam) begin
      cos_r   <= in_cos;
      sin_r   <= in_sin;
      step_r  <= in_step;
      count_r <= '0;
    end else if (cmd_i.echo_start) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.echo_start) begin
      samp_idx_r <= count_r[IDX_W-1:0];
      inten_r    <= in_int;
    end
  end

  // Echo stage 1: range along the beam and the raw hit product.
  logic [RANGE_W-1:0] range_r;
  logic [HITP_W-1:0]  hitp_r;

  always_ff @(posedge clk) begin
    if (cmd_i.e_mul1) begin
      range_r <= RANGE_W'(samp_idx_r * step_r);
      hitp_r  <= HITP_W'(hit_inc_r * inten_r);
    end
  end

  // Echo stage 2: Q.23 coordinates and the Q12.8 increment, divided by 15
  // through a multiply by the reciprocal.
  logic signed [PROD_W-1:0] qx_r;
  logic signed [PROD_W-1:0] qy_r;
  logic [INC_W-1:0]         inc_r;
  logic signed [RANGE_W:0]  range_s;
  logic [INCN_W-1:0]        inc_n;
  logic [INCP_W-1:0]        inc_p;

  assign range_s = $signed({1'b0, range_r});
  assign inc_n   = {hitp_r, 8'b0};
  assign inc_p   = INCP_W'(inc_n) * INCP_W'(RECIP15);

  always_ff @(posedge clk) begin
    if (cmd_i.e_mul2) begin
      qx_r  <= PROD_W'(range_s * cos_r);
      qy_r  <= PROD_W'(range_s * sin_r);
      inc_r <= inc_p[INCP_W-1:RECIP_SH];
    end
  end

  // Echo stage 3: truncate toward zero, offset to the centre, bounds check.
  localparam logic [PROD_W-1:0]      FRAC_MASK = PROD_W'((64'd1 << FRAC_W) - 64'd1);
  localparam logic signed [GX_W-1:0] HALF_SIDE = GX_W'(GRID_SIDE / 2);
  localparam logic signed [GX_W-1:0] SIDE_S    = GX_W'(GRID_SIDE);

  logic signed [PROD_W-1:0] qx_adj;
  logic signed [PROD_W-1:0] qy_adj;
  logic signed [GX_W-1:0]   gx;
  logic signed [GX_W-1:0]   gy;
  logic                     on_grid;
  logic [ADDR_W-1:0]        echo_addr;
  logic [ADDR_W-1:0]        addr_r;

  assign qx_adj = qx_r + (qx_r[PROD_W-1] ? $signed(FRAC_MASK) : $signed(PROD_W'(0)));
  assign qy_adj = qy_r + (qy_r[PROD_W-1] ? $signed(FRAC_MASK) : $signed(PROD_W'(0)));
  assign gx = $signed({qx_adj[PROD_W-1], qx_adj[PROD_W-1:FRAC_W]}) + HALF_SIDE;
  assign gy = $signed({qy_adj[PROD_W-1], qy_adj[PROD_W-1:FRAC_W]}) + HALF_SIDE;
  assign on_grid = !gx[GX_W-1] && (gx < SIDE_S) && !gy[GX_W-1] && (gy < SIDE_S);
  assign echo_addr = {gy[SIDE_W-1:0], gx[SIDE_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd_i.e_addr) begin
      addr_r <= echo_addr;
    end
  end

  // Echo stage 4: saturating add of the increment.
  logic [CELL_W-1:0] rdata;
  logic [SUM_W-1:0]  sum;
  logic [CELL_W-1:0] sum_sat;

  assign sum     = SUM_W'(rdata) + SUM_W'(inc_r);
  assign sum_sat = (sum > SUM_W'(CELL_MAX)) ? CELL_MAX : sum[CELL_W-1:0];

  // Decay sweep. A cell at or below the step floors at zero; the published
  // value is the integer part, which is already zero below one.
  logic [ADDR_W-1:0] ptr_r;
  logic [CELL_W-1:0] decayed;
  logic              ptr_last;

  assign decayed  = (rdata > decay_r) ? rdata - decay_r : '0;
  assign ptr_last = (ptr_r == ADDR_W'(CELL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd_i.d_write) begin
      ptr_r <= ptr_last ? '0 : ptr_r + ADDR_W'(1);
    end
  end

  // Clear pass after reset.
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // Grid memory.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    mem_we    = cmd_i.clr_step || cmd_i.e_write || cmd_i.d_write;
    mem_waddr = ptr_r;
    mem_wdata = decayed;
    if (cmd_i.clr_step) begin
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (cmd_i.e_write) begin
      mem_waddr = addr_r;
      mem_wdata = sum_sat;
    end
    mem_re    = cmd_i.d_read || (cmd_i.e_addr && on_grid);
    mem_raddr = cmd_i.d_read ? ptr_r : echo_addr;
  end

  rog_grid_ram #(
    .ADDR_BITS(ADDR_W),
    .DATA_BITS(CELL_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(rdata)
  );

  // Output register.
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [OCC_W-1:0]     out_occ_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.d_write) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.d_write) begin
      out_idx_r  <= to_index(ptr_r);
      out_occ_r  <= decayed[CELL_W-1:8];
      out_last_r <= ptr_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_occ_r, out_idx_r};
  assign out_tlast  = out_last_r;

  // Status.
  assign sts_o.op       = in_tuser;
  assign sts_o.cnt_full = (count_r >= CNT_W'(MAX_ECHOES));
  assign sts_o.hot      = (in_int > HIT_THRESHOLD);
  assign sts_o.on_grid  = on_grid;
  assign sts_o.clr_last = (clr_addr_r == ADDR_W'(CELL_COUNT - 1));
  assign sts_o.out_busy = out_valid_r && !out_tready;

  a_cell_max: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wdata <= CELL_MAX))
    else $error("grid cell written above saturation");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ECHOES))
    else $error("sample counter ran past its limit");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.d_write |-> !(out_valid_r && !out_tready))
    else $error("decay result would overwrite a pending transaction");

endmodule

[rtl/rog_ctrl.sv]
// Controller state machine of the occupancy grid block: clear pass, echo
// sequence and decay sequence. Depends on rog_pkg.

module rog_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rog_pkg::rog_sts_t sts_i,
  output rog_pkg::rog_cmd_t cmd_o
);

  import rog_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_E1   = 3'd2;
  localparam logic [2:0] S_E2   = 3'd3;
  localparam logic [2:0] S_E3   = 3'd4;
  localparam logic [2:0] S_E4   = 3'd5;
  localparam logic [2:0] S_D2   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (sts_i.op)
            OP_SECTOR: cmd_o.load_beam = 1'b1;
            OP_ECHO: begin
              if (!sts_i.cnt_full) begin
                cmd_o.echo_start = 1'b1;
                if (sts_i.hot) begin
                  state_nxt = S_E1;
                end
              end
            end
            OP_DECAY: begin
              cmd_o.d_read = 1'b1;
              state_nxt    = S_D2;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_E1: begin
        cmd_o.e_mul1 = 1'b1;
        state_nxt    = S_E2;
      end
      S_E2: begin
        cmd_o.e_mul2 = 1'b1;
        state_nxt    = S_E3;
      end
      S_E3: begin
        cmd_o.e_addr = 1'b1;
        state_nxt    = sts_i.on_grid ? S_E4 : S_IDLE;
      end
      S_E4: begin
        cmd_o.e_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_D2: begin
        if (!sts_i.out_busy) begin
          cmd_o.d_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_e4_after_e3: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_E4) |-> ($past(state_r) == S_E3))
    else $error("write-back reached without a cell lookup");

  a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == S_CLR) |-> $past(sts_i.clr_last))
    else $error("clear pass left before the last grid entry");

endmodule

[rtl/radar_occupancy_grid_update.sv]
// Top level of the radar occupancy grid update block.
// Depends on rog_pkg, rog_ctrl, rog_dp and rog_grid_ram.

// The block keeps a 1024 x 1024 grid of Q7.8 occupancy cells in one on-chip
// memory and processes one input transaction at a time. After reset it first
// runs a clearing pass that writes zero to every cell, one per cycle; in_tready
// stays low during that pass, while configuration writes are taken as usual.
// A sector-start transaction (tuser 0) loads the beam cosine, sine and range
// step. An echo transaction (tuser 1) ends on acceptance when it is dropped
// (counter full) or its intensity is 5 or less. Otherwise it runs two multiply
// stages and a coordinate and bounds stage that reads the cell, and ends there
// when its cell falls off the grid; when it scores a hit it goes on to a
// write-back of the saturated sum. The grid memory has a single read and a
// single write port. A decay transaction (tuser 2) runs a read and then a
// write-back, and produces one result transaction carrying the cell index, the
// published occupancy and tlast on the last cell of the sweep. The result sits
// in an output register, so echo and sector work goes on while it waits; a
// further decay transaction waits in its write-back step until the register
// has been taken. Transaction code 3 is accepted and ignored. Configuration
// (index 0 hit increment, index 1 decay step) must be written while idle.

module radar_occupancy_grid_update (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cos_angle[15:0], sin_angle[31:16],
                                  // range_step[47:32], intensity[55:48]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cell_index[19:0], occupancy[26:20], zero[31:27]
  output logic        out_tlast,  // sweep_last
  // Configuration port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata
);

  import rog_pkg::*;

  rog_cmd_t cmd;
  rog_sts_t sts;

  // The controller sequences each transaction; the datapath owns all storage.
  rog_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rog_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
